>>> design/qn_pkg.sv
// Shared types, widths and constants for the quaternion normaliser.
`timescale 1ns / 1ps
`default_nettype none

package qn_pkg;

  // Component format
  localparam int CW = 16;                  // component width
  localparam int FB = 12;                  // fraction bits
  localparam int NLANE = 4;                // x, y, z, w

  // Derived widths
  localparam int SUM_W  = 2 * CW + 1;      // exact sum of four squares
  localparam int ROOT_W = (SUM_W + 1) / 2; // floor(sqrt(sum)), also magnitude width
  localparam int RAD_W  = 2 * ROOT_W;      // radicand padded to whole digit pairs
  localparam int REM_W  = ROOT_W + 2;      // square-root partial remainder
  localparam int MAG_W  = ROOT_W;
  localparam int QUO_W  = FB + 1;          // |c| <= mag, so the quotient is at most 2^FB
  localparam int SAT_W  = ((QUO_W > CW) ? QUO_W : CW) + 1;

  // Saturation limits, zero-extended to SAT_W
  localparam logic [SAT_W-1:0] SAT_POS = {{(SAT_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [SAT_W-1:0] SAT_NEG = {{(SAT_W-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

  // One input item
  typedef struct packed {
    logic signed [CW-1:0] comp_x;
    logic signed [CW-1:0] comp_y;
    logic signed [CW-1:0] comp_z;
    logic signed [CW-1:0] comp_w;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic signed [CW-1:0] unit_x;
    logic signed [CW-1:0] unit_y;
    logic signed [CW-1:0] unit_z;
    logic signed [CW-1:0] unit_w;
    logic                 zero_magnitude;
  } out_item_t;

  // Per-lane sign and absolute value, carried alongside the magnitude pipeline
  typedef struct packed {
    logic [NLANE-1:0]         neg;
    logic [NLANE-1:0][CW-1:0] absv;
  } side_t;

endpackage

`default_nettype wire

>>> design/qn_sumsq.sv
// Front end: absolute values, squares and the sum of squares, four stages.
`timescale 1ns / 1ps
`default_nettype none

module qn_sumsq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire qn_pkg::in_item_t in_item,
  output logic                  sum_vld,
  output logic [qn_pkg::SUM_W-1:0] sum_val,
  output qn_pkg::side_t         sum_side
);
  import qn_pkg::*;

  logic [NLANE-1:0][CW-1:0] comp_v;
  side_t                    side_nxt;

  logic [3:0]               vld_r;
  side_t                    side1_r, side2_r, side3_r, side4_r;
  logic [NLANE-1:0][2*CW-1:0] sq_r;
  logic [1:0][SUM_W-1:0]    pair_r;
  logic [SUM_W-1:0]         sum_r;

  assign comp_v[0] = in_item.comp_x;
  assign comp_v[1] = in_item.comp_y;
  assign comp_v[2] = in_item.comp_z;
  assign comp_v[3] = in_item.comp_w;

  // Sign and magnitude of each component; the most negative value maps to 2^(CW-1)
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      side_nxt.neg[l]  = comp_v[l][CW-1];
      side_nxt.absv[l] = comp_v[l][CW-1] ? (~comp_v[l] + 1'b1) : comp_v[l];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    side1_r <= side_nxt;
    side2_r <= side1_r;
    for (int l = 0; l < NLANE; l++) begin
      sq_r[l] <= (2*CW)'(side1_r.absv[l]) * (2*CW)'(side1_r.absv[l]);
    end
    side3_r   <= side2_r;
    pair_r[0] <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]);
    pair_r[1] <= SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
    side4_r   <= side3_r;
    sum_r     <= pair_r[0] + pair_r[1];
  end

  assign sum_vld  = vld_r[3];
  assign sum_val  = sum_r;
  assign sum_side = side4_r;

endmodule

`default_nettype wire

>>> design/qn_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module qn_sqrt (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_vld,
  input  wire logic [qn_pkg::SUM_W-1:0] in_sum,
  input  wire qn_pkg::side_t           in_side,
  output logic                         root_vld,
  output logic [qn_pkg::ROOT_W-1:0]    root_val,
  output qn_pkg::side_t                root_side
);
  import qn_pkg::*;

  logic [ROOT_W-1:0] vld_r;
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W-1];
  logic [RAD_W-1:0]  rad_r  [ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    side_t             side_in;
    logic [REM_W-1:0]  rsh;
    logic [REM_W-1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    // Stage inputs: the first stage starts from the sum with an empty root
    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = RAD_W'(in_sum);
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Bring down two radicand bits and try root*4+1
    always_comb begin
      rsh      = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial    = {root_in, 2'b01};
      take     = (rsh >= trial);
      rem_nxt  = take ? (rsh - trial) : rsh;
      root_nxt = {root_in[ROOT_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      root_r[k] <= root_nxt;
      side_r[k] <= side_in;
    end

    // The last stage needs no remainder or radicand
    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        rad_r[k] <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root_vld  = vld_r[ROOT_W-1];
  assign root_val  = root_r[ROOT_W-1];
  assign root_side = side_r[ROOT_W-1];

endmodule

`default_nettype wire

>>> design/qn_div.sv
// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module qn_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_vld,
  input  wire logic [qn_pkg::MAG_W-1:0] in_mag,
  input  wire qn_pkg::side_t          in_side,
  output logic                        quo_vld,
  output logic                        quo_zero,
  output logic [qn_pkg::NLANE-1:0]    quo_neg,
  output logic [qn_pkg::NLANE-1:0][qn_pkg::QUO_W-1:0] quo_val
);
  import qn_pkg::*;

  // Each lane forms (|c| << FB) / mag. Since |c| <= mag the quotient fits
  // in FB+1 bits, so the division starts with |c| >> 1 as the remainder.
  logic [QUO_W-1:0]             vld_r;
  logic                         zero_r [QUO_W];
  logic [NLANE-1:0]             neg_r  [QUO_W];
  logic [MAG_W-1:0]             mag_r  [QUO_W-1];
  logic [NLANE-1:0][QUO_W-1:0]  quo_r  [QUO_W];
  logic [NLANE-1:0][MAG_W-1:0]  rem_r  [QUO_W-1];
  logic [NLANE-1:0][QUO_W-1:0]  dvd_r  [QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic                        vld_in;
    logic                        zero_in;
    logic [NLANE-1:0]            neg_in;
    logic [MAG_W-1:0]            mag_in;
    logic [NLANE-1:0][QUO_W-1:0] quo_in;
    logic [NLANE-1:0][MAG_W-1:0] rem_in;
    logic [NLANE-1:0][QUO_W-1:0] dvd_in;
    logic [NLANE-1:0][QUO_W-1:0] quo_nxt;
    logic [NLANE-1:0][MAG_W-1:0] rem_nxt;

    // Stage inputs
    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign zero_in = (in_mag == '0);
      assign neg_in  = in_side.neg;
      assign mag_in  = in_mag;
      assign quo_in  = '0;
      for (genvar l = 0; l < NLANE; l++) begin : g_lane
        assign rem_in[l] = MAG_W'(in_side.absv[l][CW-1:1]);
        assign dvd_in[l] = {in_side.absv[l][0], {FB{1'b0}}};
      end
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign zero_in = zero_r[k-1];
      assign neg_in  = neg_r[k-1];
      assign mag_in  = mag_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign dvd_in  = dvd_r[k-1];
    end

    // Shift in the next dividend bit and subtract the divisor where it fits
    always_comb begin
      logic [MAG_W:0] rsh;
      logic [MAG_W:0] dif;
      logic           ge;
      for (int l = 0; l < NLANE; l++) begin
        rsh        = {rem_in[l], dvd_in[l][QUO_W-1]};
        dif        = rsh - {1'b0, mag_in};
        ge         = (rsh >= {1'b0, mag_in});
        rem_nxt[l] = ge ? dif[MAG_W-1:0] : rsh[MAG_W-1:0];
        quo_nxt[l] = {quo_in[l][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      zero_r[k] <= zero_in;
      neg_r[k]  <= neg_in;
      quo_r[k]  <= quo_nxt;
    end

    // Divisor, remainder and dividend are not needed past the last stage
    if (k < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        mag_r[k] <= mag_in;
        rem_r[k] <= rem_nxt;
        for (int l = 0; l < NLANE; l++) begin
          dvd_r[k][l] <= {dvd_in[l][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_vld  = vld_r[QUO_W-1];
  assign quo_zero = zero_r[QUO_W-1];
  assign quo_neg  = neg_r[QUO_W-1];
  assign quo_val  = quo_r[QUO_W-1];

endmodule

`default_nettype wire

>>> design/quaternion_normaliser_core.sv
// Top level of the quaternion normaliser: sum of squares, square root, divide, saturate.
//
//   channel   ports                          handshake
//   input     start, busy, in_item           taken when start && !busy
//   result    out_valid, out_item            one-cycle strobe, no back-pressure
//
// One item per clock cycle, sustained; busy is never raised.
// The pipeline has 4 front-end stages, 17 square-root stages (one root
// bit each), 13 divider stages (one quotient bit each) and the output register.
// Synchronous active-low reset clears every valid bit; payload is not reset.
// The pipeline never stalls; the receiver must always take a result, unchecked.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_normaliser_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire qn_pkg::in_item_t  in_item,
  output logic                   out_valid,
  output qn_pkg::out_item_t      out_item
);
  import qn_pkg::*;

  logic                         sum_vld;
  logic [SUM_W-1:0]             sum_val;
  side_t                        sum_side;
  logic                         root_vld;
  logic [ROOT_W-1:0]            root_val;
  side_t                        root_side;
  logic                         quo_vld;
  logic                         quo_zero;
  logic [NLANE-1:0]             quo_neg;
  logic [NLANE-1:0][QUO_W-1:0]  quo_val;
  logic [NLANE-1:0][CW-1:0]     unit_nxt;
  out_item_t                    out_item_nxt;
  logic                         out_valid_r;
  out_item_t                    out_item_r;

  // Clamp a quotient to the component range and apply the sign
  function automatic logic [CW-1:0] to_unit(input logic [QUO_W-1:0] q, input logic neg);
    logic [SAT_W-1:0] qx;
    logic [SAT_W-1:0] lim;
    logic [SAT_W-1:0] res;
    qx = SAT_W'(q);
    if (neg) begin
      lim = (qx > SAT_NEG) ? SAT_NEG : qx;
      res = ~lim + 1'b1;
    end else begin
      lim = (qx > SAT_POS) ? SAT_POS : qx;
      res = lim;
    end
    return res[CW-1:0];
  endfunction

  assign busy = 1'b0;

  qn_sumsq u_sumsq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_item  (in_item),
    .sum_vld  (sum_vld),
    .sum_val  (sum_val),
    .sum_side (sum_side)
  );

  qn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (sum_vld),
    .in_sum    (sum_val),
    .in_side   (sum_side),
    .root_vld  (root_vld),
    .root_val  (root_val),
    .root_side (root_side)
  );

  qn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (root_vld),
    .in_mag   (root_val),
    .in_side  (root_side),
    .quo_vld  (quo_vld),
    .quo_zero (quo_zero),
    .quo_neg  (quo_neg),
    .quo_val  (quo_val)
  );

  // Zero magnitude only occurs for an all-zero item, which passes through as zeros
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      unit_nxt[l] = quo_zero ? '0 : to_unit(quo_val[l], quo_neg[l]);
    end
    out_item_nxt.unit_x         = unit_nxt[0];
    out_item_nxt.unit_y         = unit_nxt[1];
    out_item_nxt.unit_z         = unit_nxt[2];
    out_item_nxt.unit_w         = unit_nxt[3];
    out_item_nxt.zero_magnitude = quo_zero;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
